>>> rtl/core/rrt_pkg.sv
// Package: shared constants and types for the received range tracker
`default_nettype none
package rrt_pkg;
  localparam int unsigned MAX_RANGES_DEF  = 16;
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;
endpackage
`default_nettype wire

>>> rtl/core/received_range_tracker.sv
// Top level: sorted range list held in a start/end memory, scanned and shifted in place
// Flow: an invalid range ends in the scan; otherwise scan, decide, then merge, drop or insert, then done.
// A merge rewrites the entry before; a double merge also shifts later entries down; an insert shifts up.
// One request at a time; busy is high from start until the result strobe.
// The scan and a double merge move one entry a cycle; an insert reads and writes each moved entry in turn.
// Reset clears count and control, not the range memory; out_valid strobes once, no stall.
`default_nettype none
module received_range_tracker
  import rrt_pkg::*;
#(
  parameter int unsigned MAX_RANGES  = MAX_RANGES_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [IN_W-1:0]     in_range_start,
  input  wire logic [IN_W-1:0]     in_range_end,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_range_count
);
  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned OW = OFFSET_BITS;
  localparam int unsigned EW = 2 * OW;
  localparam logic [CW-1:0] CMAX = CW'(MAX_RANGES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_MRG   = 7'b0001000,
    S_DROP  = 7'b0010000,
    S_INS   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  logic [EW-1:0] mem [MAX_RANGES];

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          pos_found_r, pos_found_nxt;
  logic          busy_hit_r, busy_hit_nxt;
  logic          prev_adj_r, prev_adj_nxt;
  logic          next_adj_r, next_adj_nxt;
  logic [OW-1:0] next_end_r, next_end_nxt;
  logic [OW-1:0] s_r, e_r;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic          rd_v_r;
  logic [CW-1:0] rd_i_r;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_a, wr_a;
  logic [EW-1:0] wr_d, rd_q_r;
  logic [OW-1:0] q_s, q_e;

  assign q_s = rd_q_r[EW-1:OW];
  assign q_e = rd_q_r[OW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (rd_en) rd_q_r <= mem[rd_a];
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r; pos_nxt = pos_r;
    pos_found_nxt = pos_found_r; busy_hit_nxt = busy_hit_r;
    prev_adj_nxt = prev_adj_r; next_adj_nxt = next_adj_r;
    next_end_nxt = next_end_r; st_nxt = st_r;
    rd_en = 1'b0; rd_a = '0; wr_en = 1'b0; wr_a = '0; wr_d = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt = '0; pos_nxt = count_r; pos_found_nxt = 1'b0;
          busy_hit_nxt = 1'b0; prev_adj_nxt = 1'b0; next_adj_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue read idx_r, evaluate previous read
        if (s_r >= e_r) begin
          st_nxt = ST_INVALID; state_nxt = S_DONE;
        end else begin
          if (idx_r < count_r) begin
            rd_en = 1'b1; rd_a = AW'(idx_r); idx_nxt = idx_r + 1'b1;
          end
          if (rd_v_r) begin
            if (s_r < q_e && e_r > q_s) busy_hit_nxt = 1'b1;
            if (!pos_found_r && !(q_s < s_r)) begin
              pos_found_nxt = 1'b1; pos_nxt = rd_i_r;
              next_adj_nxt = (q_s == e_r); next_end_nxt = q_e;
            end
            if (!pos_found_r && q_s < s_r) prev_adj_nxt = (q_e == s_r);
          end
          if (idx_r >= count_r && !rd_v_r) state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (busy_hit_r) begin
          st_nxt = ST_BUSY; state_nxt = S_DONE;
        end else if (prev_adj_r) begin
          st_nxt = ST_OK; state_nxt = S_MRG;
        end else if (next_adj_r) begin
          wr_en = 1'b1; wr_a = AW'(pos_r); wr_d = {s_r, next_end_r};
          st_nxt = ST_OK; state_nxt = S_DONE;
        end else if (count_r >= CMAX) begin
          st_nxt = ST_FULL; state_nxt = S_DONE;
        end else begin
          st_nxt = ST_OK; idx_nxt = count_r; state_nxt = S_INS;
        end
      end
      S_MRG: begin
        // read entry pos-1 start, rewrite with new end
        rd_en = 1'b1; rd_a = AW'(pos_r - 1'b1);
        if (rd_v_r) begin
          wr_en = 1'b1; wr_a = AW'(pos_r - 1'b1);
          wr_d = {q_s, (next_adj_r ? next_end_r : e_r)};
          rd_en = 1'b0;
          if (next_adj_r) begin
            idx_nxt = pos_r + 1'b1; state_nxt = S_DROP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DROP: begin
        // move entry idx down by one
        if (rd_v_r) begin
          wr_en = 1'b1; wr_a = AW'(rd_i_r - 1'b1); wr_d = rd_q_r;
        end
        if (idx_r < count_r) begin
          rd_en = 1'b1; rd_a = AW'(idx_r); idx_nxt = idx_r + 1'b1;
        end else if (!rd_v_r) begin
          count_nxt = count_r - 1'b1; state_nxt = S_DONE;
        end
      end
      S_INS: begin
        // move entry idx-1 up by one, top down
        if (rd_v_r) begin
          wr_en = 1'b1; wr_a = AW'(rd_i_r + 1'b1); wr_d = rd_q_r;
        end else if (idx_r > pos_r) begin
          rd_en = 1'b1; rd_a = AW'(idx_r - 1'b1); idx_nxt = idx_r - 1'b1;
        end else begin
          wr_en = 1'b1; wr_a = AW'(pos_r); wr_d = {s_r, e_r};
          count_nxt = count_r + 1'b1; state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; rd_v_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt;
      rd_v_r <= rd_en; out_valid <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; pos_r <= pos_nxt; pos_found_r <= pos_found_nxt;
    busy_hit_r <= busy_hit_nxt; prev_adj_r <= prev_adj_nxt; next_adj_r <= next_adj_nxt;
    next_end_r <= next_end_nxt; st_r <= st_nxt;
    if (rd_en) begin
      if (state_r == S_INS) rd_i_r <= idx_r - 1'b1;
      else if (state_r == S_MRG) rd_i_r <= pos_r - 1'b1;
      else rd_i_r <= idx_r;
    end
    if (state_r == S_IDLE && start) begin
      s_r <= OW'(in_range_start);
      e_r <= OW'(in_range_end);
    end
    out_status <= st_r;
    out_range_count <= COUNT_W'(count_r);
  end

  assign busy = (state_r != S_IDLE);

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CMAX)
    else $error("range count exceeds table size");
  a_one_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_DROP || $past(state_r) == S_INS))
    else $error("count changed outside a shift");
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !wr_en)
    else $error("memory written while idle");
endmodule
`default_nettype wire
